// File: src/cfc_pkg.sv
// Shared types, constants and the byte-wide CRC-16/XMODEM update for the
// command frame checker. No dependencies.
package cfc_pkg;

  localparam int unsigned WinLen = 8;
  localparam int unsigned CntW   = 4;

  localparam logic [7:0]  ByteCr   = 8'h0D;
  localparam logic [7:0]  ByteLf   = 8'h0A;
  localparam logic [7:0]  ByteGet  = 8'h47;
  localparam logic [7:0]  ByteLed  = 8'h4C;
  localparam logic [15:0] CrcPoly  = 16'h1021;
  localparam logic [15:0] CrcInit  = 16'h0000;

  typedef enum logic [1:0] {
    KIND_NONE = 2'd0,
    KIND_GET  = 2'd1,
    KIND_LED  = 2'd2
  } cmd_kind_t;

  // One window slot: the byte and the CRCs of the runs of one to four
  // bytes that end with it.
  typedef struct packed {
    logic [7:0]  data;
    logic [15:0] r1;
    logic [15:0] r2;
    logic [15:0] r3;
    logic [15:0] r4;
  } cell_t;

  typedef logic [WinLen-1:0][7:0] win_t;

  typedef struct packed {
    cmd_kind_t  kind;
    logic [7:0] b0;
    logic [7:0] b1;
    logic [7:0] b2;
  } cmd_t;

  function automatic logic [15:0] crc_byte(input logic [15:0] crc_in,
                                           input logic [7:0]  din);
    logic [15:0] c;
    c = crc_in ^ {din, 8'h00};
    for (int b = 0; b < 8; b++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CrcPoly;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

// File: src/cfc_cell.sv
// One slot of the shift window: takes its neighbor's contents on a shift,
// clears on a frame end. Depends on cfc_pkg.
module cfc_cell (
  input  logic            clk,
  input  logic            rst,
  input  logic            shift,
  input  logic            clear,
  input  cfc_pkg::cell_t  d,
  output cfc_pkg::cell_t  q
);

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      q <= '0;
    end else if (shift) begin
      q <= d;
    end
  end

endmodule

// File: src/cfc_check.sv
// Frame decode: terminator, command byte and CRC compare on the window as it
// stands after the current byte. Depends on cfc_pkg.
module cfc_check (
  input  cfc_pkg::win_t  win,
  input  logic [15:0]    crc,
  input  logic           full,
  output cfc_pkg::cmd_t  cmd
);

  logic is_get;
  logic is_led;
  logic frame_ok;

  assign is_get   = (win[0] == cfc_pkg::ByteGet);
  assign is_led   = (win[0] == cfc_pkg::ByteLed);
  assign frame_ok = full && (win[6] == cfc_pkg::ByteCr) && (win[7] == cfc_pkg::ByteLf)
                    && (crc == {win[4], win[5]});

  always_comb begin
    cmd = '0;
    cmd.kind = cfc_pkg::KIND_NONE;
    if (frame_ok && is_get) begin
      cmd.kind = cfc_pkg::KIND_GET;
    end else if (frame_ok && is_led) begin
      cmd.kind = cfc_pkg::KIND_LED;
      cmd.b0   = win[1];
      cmd.b1   = win[2];
      cmd.b2   = win[3];
    end
  end

endmodule

// File: src/command_frame_checker_core.sv
// Top level of the command frame checker: eight-cell byte window with
// rolling CRCs, frame decode and a two-entry result buffer.
// Depends on cfc_pkg, cfc_cell and cfc_check.
//
//  port group | dir | fields (low bit up)                      | note
//  s_*        | in  | tdata: rx_byte[7:0]; tlast: frame_end    | one byte per transaction
//  m_*        | out | tdata: cmd_byte0, cmd_byte1, cmd_byte2;  | one transaction per
//             |     | tuser: cmd_kind[1:0]                     | frame end
//
// One byte per cycle while s_tready is high; each frame end's result is
// registered and presented on m_*; new CRCs extend the head cell's by the byte.
// Reset clears the window, byte count and result buffer.
// s_tready drops only while both result slots are full; bytes without
// tlast are taken while the output stalls until that point.
module command_frame_checker_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // rx_byte[7:0]
  input  logic        s_tlast,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // cmd_byte0[7:0], cmd_byte1[15:8], cmd_byte2[23:16]
  output logic [1:0]  m_tuser    // cmd_kind[1:0]
);

  localparam int unsigned W = cfc_pkg::WinLen;

  cfc_pkg::cell_t q [W];
  cfc_pkg::cell_t entry;
  cfc_pkg::win_t  win;
  cfc_pkg::cmd_t  res;
  cfc_pkg::cmd_t  out_reg;
  cfc_pkg::cmd_t  skid_reg;

  logic [cfc_pkg::CntW-1:0] count;
  logic [cfc_pkg::CntW-1:0] count_next;
  logic acc;
  logic push;
  logic pop;
  logic out_valid;
  logic skid_valid;
  logic full;

  assign s_tready = !skid_valid;
  assign acc      = s_tvalid && s_tready;
  assign push     = acc && s_tlast;
  assign pop      = m_tvalid && m_tready;

  always_comb begin
    entry.data = s_tdata;
    entry.r1   = cfc_pkg::crc_byte(cfc_pkg::CrcInit, s_tdata);
    entry.r2   = cfc_pkg::crc_byte(q[W-1].r1, s_tdata);
    entry.r3   = cfc_pkg::crc_byte(q[W-1].r2, s_tdata);
    entry.r4   = cfc_pkg::crc_byte(q[W-1].r3, s_tdata);
  end

  genvar k;
  generate
    for (k = 0; k < W; k++) begin : g_cell
      if (k == W - 1) begin : g_head
        cfc_cell u_cell (
          .clk(clk), .rst(rst), .shift(acc), .clear(push), .d(entry), .q(q[k])
        );
      end else begin : g_body
        cfc_cell u_cell (
          .clk(clk), .rst(rst), .shift(acc), .clear(push), .d(q[k+1]), .q(q[k])
        );
      end
    end
  endgenerate

  // window after the current byte is shifted in
  always_comb begin
    for (int i = 0; i < W - 1; i++) begin
      win[i] = q[i+1].data;
    end
    win[W-1] = s_tdata;
  end

  assign full = (count >= cfc_pkg::CntW'(W - 1));

  cfc_check u_check (
    .win(win),
    .crc(q[4].r4),
    .full(full),
    .cmd(res)
  );

  always_comb begin
    count_next = count;
    if (push) begin
      count_next = '0;
    end else if (acc && (count < cfc_pkg::CntW'(W))) begin
      count_next = count + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid) begin
      out_valid <= push;
    end else if (pop) begin
      if (skid_valid) begin
        skid_valid <= 1'b0;
      end else begin
        out_valid <= push;
      end
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || (pop && !skid_valid)) begin
      if (push) begin
        out_reg <= res;
      end
    end else if (pop) begin
      out_reg <= skid_reg;
    end
    if (out_valid && !pop && push) begin
      skid_reg <= res;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {out_reg.b2, out_reg.b1, out_reg.b0};
  assign m_tuser  = 2'(out_reg.kind);

  a_skid_needs_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid slot holds a result while output slot is empty");

  a_clear_on_end: assert property (@(posedge clk) disable iff (rst)
    push |=> (count == '0) && (q[W-1] == '0) && (q[0] == '0))
    else $error("window not cleared after frame end");

  a_count_sat: assert property (@(posedge clk) disable iff (rst)
    count <= cfc_pkg::CntW'(W))
    else $error("byte count above window length");

  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    (!push && !pop) |=> $stable(out_valid) && $stable(skid_valid))
    else $error("result buffer changed without a frame end or a drain");

endmodule
